>>> rtl/core/atns_pkg.sv
`timescale 1ns / 1ps

package atns_pkg;

    // Table geometry
    localparam int ALARM_COUNT  = 8;
    localparam int DEVICE_COUNT = 4;
    localparam int SLOT_W       = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

    // Field widths
    localparam int OP_W   = 2;
    localparam int SL_W   = 8;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int DEV_W  = 4;

    // Seconds of day: 31*3600 + 63*60 + 63 fits in 17 bits
    localparam int TOD_W = 17;
    // Distance keeps two extra bits so wrapped negatives sort above all
    localparam int DIST_W = TOD_W + 2;

    localparam logic [TOD_W-1:0]  SEC_PER_HOUR = TOD_W'(3600);
    localparam logic [TOD_W-1:0]  SEC_PER_MIN  = TOD_W'(60);
    localparam logic [DIST_W-1:0] DAY_SECONDS  = DIST_W'(86400);

    localparam logic [DEV_W-1:0] DEV_MASK =
        (DEVICE_COUNT >= DEV_W) ? {DEV_W{1'b1}} : DEV_W'((1 << DEVICE_COUNT) - 1);

    // Item operations
    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_EVENT    = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    // One stored alarm (active flag is kept apart in flip-flops)
    typedef struct packed {
        logic              daily;
        logic [DEV_W-1:0]  devices;
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
    } entry_t;

    // Result item
    typedef struct packed {
        logic [DEV_W-1:0]  device_states;
        logic              fired;
        logic [SEC_W-1:0]  second_sec;
        logic [MIN_W-1:0]  second_minute;
        logic [HOUR_W-1:0] second_hour;
        logic              second_valid;
        logic [SEC_W-1:0]  first_second;
        logic [MIN_W-1:0]  first_minute;
        logic [HOUR_W-1:0] first_hour;
        logic              first_valid;
        logic              rejected;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic apply;
        logic scan;
        logic publish;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rejected;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

    // Seconds of day from a time
    function automatic logic [TOD_W-1:0] to_seconds(
        input logic [HOUR_W-1:0] h,
        input logic [MIN_W-1:0]  m,
        input logic [SEC_W-1:0]  s
    );
        logic [TOD_W-1:0] hs;
        logic [TOD_W-1:0] ms;
        hs = TOD_W'(h) * SEC_PER_HOUR;
        ms = TOD_W'(m) * SEC_PER_MIN;
        return hs + ms + TOD_W'(s);
    endfunction

endpackage

>>> rtl/core/atns_ctrl.sv
`timescale 1ns / 1ps

module atns_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  atns_pkg::dp_status_t   status,
    output atns_pkg::ctrl_cmd_t    cmd
);
    import atns_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_APPLY = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new transaction only when idle and out of reset
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.rejected ? ST_HOLD : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/atns_datapath.sv
`timescale 1ns / 1ps

module atns_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  atns_pkg::ctrl_cmd_t         cmd,
    output atns_pkg::dp_status_t        status,
    input  logic [atns_pkg::OP_W-1:0]   in_op,
    input  logic [atns_pkg::SL_W-1:0]   in_slot,
    input  atns_pkg::entry_t            in_entry,
    input  logic [atns_pkg::HOUR_W-1:0] in_now_hour,
    input  logic [atns_pkg::MIN_W-1:0]  in_now_minute,
    input  logic [atns_pkg::SEC_W-1:0]  in_now_second,
    input  logic                        m_tready,
    output logic                        out_valid,
    output atns_pkg::result_t           out_result
);
    import atns_pkg::*;

    // Captured transaction
    op_t               op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              reject_reg;
    entry_t            new_entry_reg;
    logic [HOUR_W-1:0] now_hour_reg;
    logic [MIN_W-1:0]  now_minute_reg;
    logic [SEC_W-1:0]  now_second_reg;
    logic [TOD_W-1:0]  now_tod_reg;

    // Table storage
    entry_t                 entry_mem [ALARM_COUNT];
    logic [ALARM_COUNT-1:0] active_reg;

    // Scan pipeline
    logic [SLOT_W-1:0] scan_idx_reg;
    logic              v1_reg;
    logic [SLOT_W-1:0] idx1_reg;
    entry_t            rd_entry_reg;
    logic              rd_active_reg;
    logic              v2_reg;
    logic [SLOT_W-1:0] idx2_reg;
    entry_t            ent2_reg;
    logic [DIST_W-1:0] dist2_reg;
    logic              cand2_reg;
    logic              match2_reg;

    // Working result and running best distances
    result_t           work_reg;
    logic [DIST_W-1:0] dist_a_reg;
    logic [DIST_W-1:0] dist_b_reg;

    // Output register
    logic    out_valid_reg;
    result_t out_reg;

    logic              in_bad;
    logic [TOD_W-1:0]  at_tod;
    logic [DIST_W-1:0] dist1;
    logic              match1;
    logic              is_event;

    assign in_bad = (op_t'(in_op) == OP_RESERVED) ||
                    ((op_t'(in_op) != OP_EVENT) && (in_slot >= SL_W'(ALARM_COUNT)));
    assign is_event = (op_reg == OP_EVENT);

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= op_t'(in_op);
            slot_reg       <= in_slot[SLOT_W-1:0];
            reject_reg     <= in_bad;
            new_entry_reg  <= in_entry;
            now_hour_reg   <= in_now_hour;
            now_minute_reg <= in_now_minute;
            now_second_reg <= in_now_second;
            now_tod_reg    <= to_seconds(in_now_hour, in_now_minute, in_now_second);
        end
    end

    // Table write port and registered read port
    always_ff @(posedge aclk) begin
        if (cmd.apply && !reject_reg && op_reg == OP_ADD) begin
            entry_mem[slot_reg] <= new_entry_reg;
        end
        if (cmd.scan) begin
            rd_entry_reg <= entry_mem[scan_idx_reg];
        end
    end

    // Active flags: set by add, clear by clear or by a one-shot firing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else begin
            if (cmd.apply && !reject_reg) begin
                if (op_reg == OP_ADD) begin
                    active_reg[slot_reg] <= 1'b1;
                end else if (op_reg == OP_CLEAR) begin
                    active_reg[slot_reg] <= 1'b0;
                end
            end
            if (v2_reg && match2_reg && !ent2_reg.daily) begin
                active_reg[idx2_reg] <= 1'b0;
            end
        end
    end

    // Scan address counter and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            if (cmd.capture) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan) begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
            v1_reg <= cmd.scan;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            idx1_reg      <= scan_idx_reg;
            rd_active_reg <= active_reg[scan_idx_reg];
        end
    end

    // Stage 1: distance ahead of now and match against now
    assign at_tod = to_seconds(rd_entry_reg.hour, rd_entry_reg.minute, rd_entry_reg.second);
    always_comb begin
        dist1 = DIST_W'(at_tod) - DIST_W'(now_tod_reg);
        if (at_tod < now_tod_reg) begin
            dist1 = dist1 + DAY_SECONDS;
        end
    end
    assign match1 = rd_active_reg && is_event &&
                    (rd_entry_reg.hour == now_hour_reg) &&
                    (rd_entry_reg.minute == now_minute_reg) &&
                    (rd_entry_reg.second == now_second_reg);

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            idx2_reg   <= idx1_reg;
            ent2_reg   <= rd_entry_reg;
            dist2_reg  <= dist1;
            match2_reg <= match1;
            // A firing one-shot is already gone when scheduling
            cand2_reg  <= rd_active_reg && !(match1 && !rd_entry_reg.daily);
        end
    end

    // Stage 2: fire and keep the two nearest
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            work_reg   <= '0;
            dist_a_reg <= '0;
            dist_b_reg <= '0;
        end else if (cmd.apply) begin
            work_reg.rejected <= reject_reg;
        end else if (v2_reg) begin
            if (match2_reg) begin
                work_reg.fired         <= 1'b1;
                work_reg.device_states <= ent2_reg.devices & DEV_MASK;
            end
            if (cand2_reg) begin
                if (!work_reg.first_valid || dist2_reg < dist_a_reg) begin
                    work_reg.second_valid  <= work_reg.first_valid;
                    work_reg.second_hour   <= work_reg.first_hour;
                    work_reg.second_minute <= work_reg.first_minute;
                    work_reg.second_sec    <= work_reg.first_second;
                    dist_b_reg             <= dist_a_reg;
                    work_reg.first_valid   <= 1'b1;
                    work_reg.first_hour    <= ent2_reg.hour;
                    work_reg.first_minute  <= ent2_reg.minute;
                    work_reg.first_second  <= ent2_reg.second;
                    dist_a_reg             <= dist2_reg;
                end else if (!work_reg.second_valid || dist2_reg < dist_b_reg) begin
                    work_reg.second_valid  <= 1'b1;
                    work_reg.second_hour   <= ent2_reg.hour;
                    work_reg.second_minute <= ent2_reg.minute;
                    work_reg.second_sec    <= ent2_reg.second;
                    dist_b_reg             <= dist2_reg;
                end
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_reg <= work_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign status.rejected  = reject_reg;
    assign status.scan_last = (scan_idx_reg == SLOT_W'(ALARM_COUNT - 1));
    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

endmodule

>>> rtl/core/alarm_table_next_two_scheduler.sv
`timescale 1ns / 1ps
// An accepted transaction is captured, applied to the table, then scanned one entry per
// cycle through the single memory read port; the scan pipeline drains and the result is
// published to a registered m_tvalid once the output is free. A rejected transaction
// skips the scan. A new transaction is taken only after the previous result is published.
// Reset (aresetn low, synchronous) clears all active flags and both handshakes.

module alarm_table_next_two_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op
    input  logic [1:0]  s_tuser,
    // slot, alarm_hour, alarm_minute, alarm_second, alarm_devices, daily,
    // now_hour, now_minute, now_second
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // rejected, first_valid, first_hour, first_minute, first_second, second_valid,
    // second_hour, second_minute, second_sec, fired, device_states
    output logic [47:0] m_tdata
);
    import atns_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    entry_t     in_entry;
    result_t    result;

    // Unpack the input transaction
    assign in_entry.hour    = s_tdata[12:8];
    assign in_entry.minute  = s_tdata[18:13];
    assign in_entry.second  = s_tdata[24:19];
    assign in_entry.devices = s_tdata[28:25];
    assign in_entry.daily   = s_tdata[29];

    atns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    atns_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_op         (s_tuser),
        .in_slot       (s_tdata[7:0]),
        .in_entry      (in_entry),
        .in_now_hour   (s_tdata[34:30]),
        .in_now_minute (s_tdata[40:35]),
        .in_now_second (s_tdata[46:41]),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_result    (result)
    );

    // Pack the result transaction, lowest field first
    assign m_tdata = {6'b0, result};

endmodule
